FILE: hw/rtl/bfha_pkg.sv
`timescale 1ns / 1ps
package bfha_pkg;

  // heap geometry
  localparam int unsigned HeapBytes   = 4096;
  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned SplitMin    = 5;

  localparam int unsigned Hdr   = (HeaderBytes + 1) & ~1;
  localparam int unsigned Span  = HeapBytes & ~1;
  localparam int unsigned Slots = HeapBytes / 2;

  localparam int unsigned HW  = 13;             // header width
  localparam int unsigned OW  = 14;             // walk offset width, room for overshoot
  localparam int unsigned IW  = $clog2(Slots);  // header store index width

  localparam logic [HW-1:0] InitHdr = HW'(Span - Hdr);

  // result codes
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StZero    = 3'd1;
  localparam logic [2:0] StTooBig  = 3'd2;
  localparam logic [2:0] StOom     = 3'd3;
  localparam logic [2:0] StNoFit   = 3'd4;
  localparam logic [2:0] StRange   = 3'd5;
  localparam logic [2:0] StInvalid = 3'd6;
  localparam logic [2:0] StFreed   = 3'd7;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [11:0] req_size;
    logic [11:0] release_offset;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] payload_offset;
    logic [11:0] free_bytes;
  } out_word_t;

  // classified request handed from front to back
  typedef struct packed {
    logic          cmd;
    logic [2:0]    pre;     // early reject code, StOk if none
    logic [11:0]   req;
    logic [HW-1:0] need;    // size rounded up to even
    logic [OW-1:0] target;  // header offset of chunk to free
  } job_t;

endpackage

FILE: hw/rtl/bfha_front.sv
`timescale 1ns / 1ps
module bfha_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bfha_pkg::in_word_t in_word_i,
  output logic              job_valid_o,
  input  logic              job_pop_i,
  output bfha_pkg::job_t    job_o
);
  import bfha_pkg::*;

  job_t       cls;
  job_t       q_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  // classify
  always_comb begin
    cls.cmd    = in_word_i.cmd;
    cls.req    = in_word_i.req_size;
    cls.need   = (HW'(in_word_i.req_size) + HW'(1)) & ~HW'(1);
    cls.target = OW'(in_word_i.release_offset) - OW'(Hdr);
    cls.pre    = StOk;
    if (in_word_i.cmd == CmdAlloc) begin
      if (in_word_i.req_size == '0) cls.pre = StZero;
    end else begin
      if (OW'(in_word_i.release_offset) < OW'(Hdr) ||
          OW'(in_word_i.release_offset) > OW'(Span)) cls.pre = StRange;
    end
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = job_pop_i && (cnt_q != 2'd0);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: hw/rtl/bfha_back.sv
`timescale 1ns / 1ps
module bfha_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_pop_o,
  input  bfha_pkg::job_t      job_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bfha_pkg::out_word_t out_word_o
);
  import bfha_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_A_RD  = 4'd1;
  localparam logic [3:0] S_A_EV  = 4'd2;
  localparam logic [3:0] S_A_COM = 4'd3;
  localparam logic [3:0] S_A_SPL = 4'd4;
  localparam logic [3:0] S_F_CHK = 4'd5;
  localparam logic [3:0] S_F_RD  = 4'd6;
  localparam logic [3:0] S_F_EV  = 4'd7;
  localparam logic [3:0] S_F_TRD = 4'd8;
  localparam logic [3:0] S_F_TEV = 4'd9;
  localparam logic [3:0] S_F_PRD = 4'd10;
  localparam logic [3:0] S_F_PEV = 4'd11;
  localparam logic [3:0] S_F_NCK = 4'd12;
  localparam logic [3:0] S_F_NRD = 4'd13;
  localparam logic [3:0] S_F_NEV = 4'd14;

  logic [HW-1:0] mem [Slots];
  logic [HW-1:0] rdat_q;
  logic          rz_q, e0_wr_q;

  logic [3:0]    state_q, state_d;
  logic [HW-1:0] cnt_q, cnt_d;
  logic [OW-1:0] off_q, off_d, prev_q, prev_d, best_off_q, best_off_d, start_q, start_d;
  logic [HW-1:0] best_d_q, best_d_d, hsz_q, hsz_d, sval_q, sval_d;
  logic          have_prev_q, have_prev_d, found_q, found_d;
  job_t          job_q, job_d;
  logic          out_valid_q, out_valid_d;
  out_word_t     out_q, out_d;

  logic          rd_en, wr_en, fin;
  logic [OW-1:0] rd_off, wr_off, off_nx, nxt;
  logic [HW-1:0] wr_dat, h, sz, diff, take;

  assign h      = rz_q ? InitHdr : rdat_q;
  assign sz     = {h[HW-1:1], 1'b0};
  assign diff   = sz - job_q.need;
  assign off_nx = off_q + OW'(sz) + OW'(Hdr);
  assign nxt    = off_q + OW'(hsz_q) + OW'(Hdr);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    off_d       = off_q;
    prev_d      = prev_q;
    best_off_d  = best_off_q;
    best_d_d    = best_d_q;
    hsz_d       = hsz_q;
    sval_d      = sval_q;
    start_d     = start_q;
    have_prev_d = have_prev_q;
    found_d     = found_q;
    job_d       = job_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    job_pop_o   = 1'b0;
    rd_en       = 1'b0;
    rd_off      = off_q;
    wr_en       = 1'b0;
    wr_off      = off_q;
    wr_dat      = '0;
    take        = '0;
    fin         = 1'b0;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i && !out_valid_q) begin
          job_pop_o   = 1'b1;
          job_d       = job_i;
          off_d       = '0;
          found_d     = 1'b0;
          have_prev_d = 1'b0;
          best_d_d    = '0;
          out_d.payload_offset = '0;
          if (job_i.pre != StOk) begin
            fin = 1'b1; out_d.status = job_i.pre;
          end else if (job_i.cmd == CmdFree) begin
            state_d = S_F_CHK;
          end else if (cnt_q == '0) begin
            fin = 1'b1; out_d.status = StOom;
          end else if (HW'(job_i.req) > cnt_q) begin
            fin = 1'b1; out_d.status = StTooBig;
          end else begin
            state_d = S_A_RD;
          end
        end
      end
      S_A_RD: begin
        rd_en = 1'b1; state_d = S_A_EV;
      end
      S_A_EV: begin
        if (!h[0] && sz >= job_q.need) begin
          if (!found_q || diff < best_d_q) begin
            found_d = 1'b1; best_d_d = diff; best_off_d = off_q;
          end
        end
        off_d = off_nx;
        if ((!h[0] && sz >= job_q.need && diff == '0) || off_nx >= OW'(Span))
          state_d = S_A_COM;
        else
          state_d = S_A_RD;
      end
      S_A_COM: begin
        out_d.payload_offset = 12'(best_off_q + OW'(Hdr));
        wr_off = best_off_q;
        if (!found_q) begin
          fin = 1'b1; out_d.status = StNoFit; out_d.payload_offset = '0;
        end else if (best_d_q == '0) begin
          wr_en = 1'b1; wr_dat = job_q.need | HW'(1); take = job_q.need;
          fin = 1'b1; out_d.status = StOk;
        end else if (best_d_q >= HW'(SplitMin) && best_d_q > HW'(Hdr)) begin
          wr_en = 1'b1; wr_dat = job_q.need | HW'(1); take = job_q.need + HW'(Hdr);
          state_d = S_A_SPL;
        end else begin
          wr_en = 1'b1; wr_dat = (job_q.need + best_d_q) | HW'(1);
          take = job_q.need + best_d_q;
          fin = 1'b1; out_d.status = StOk;
        end
        cnt_d = (take > cnt_q) ? '0 : cnt_q - take;
      end
      S_A_SPL: begin
        wr_en  = 1'b1;
        wr_off = best_off_q + OW'(Hdr) + OW'(job_q.need);
        wr_dat = best_d_q - HW'(Hdr);
        fin = 1'b1; out_d.status = StOk;
      end
      S_F_CHK: begin
        if (off_q >= OW'(Span) || off_q >= job_q.target) begin
          if (off_q >= OW'(Span) || off_q != job_q.target) begin
            fin = 1'b1; out_d.status = StInvalid;
          end else begin
            state_d = S_F_TRD;
          end
        end else begin
          state_d = S_F_RD;
        end
      end
      S_F_RD: begin
        rd_en = 1'b1; state_d = S_F_EV;
      end
      S_F_EV: begin
        prev_d = off_q; have_prev_d = 1'b1; off_d = off_nx; state_d = S_F_CHK;
      end
      S_F_TRD: begin
        rd_en = 1'b1; state_d = S_F_TEV;
      end
      S_F_TEV: begin
        if (!h[0]) begin
          fin = 1'b1; out_d.status = StFreed;
        end else begin
          wr_en = 1'b1; wr_dat = sz;
          cnt_d = cnt_q + sz;
          hsz_d = sz; start_d = off_q; sval_d = sz;
          state_d = have_prev_q ? S_F_PRD : S_F_NCK;
        end
      end
      S_F_PRD: begin
        rd_en = 1'b1; rd_off = prev_q; state_d = S_F_PEV;
      end
      S_F_PEV: begin
        if (!h[0]) begin
          wr_en = 1'b1; wr_off = prev_q; wr_dat = h + hsz_q + HW'(Hdr);
          cnt_d = cnt_q + HW'(Hdr);
          start_d = prev_q; sval_d = h + hsz_q + HW'(Hdr);
        end
        state_d = S_F_NCK;
      end
      S_F_NCK: begin
        if (nxt < OW'(Span)) begin
          state_d = S_F_NRD;
        end else begin
          fin = 1'b1; out_d.status = StOk;
        end
      end
      S_F_NRD: begin
        rd_en = 1'b1; rd_off = nxt; state_d = S_F_NEV;
      end
      S_F_NEV: begin
        if (!h[0]) begin
          wr_en = 1'b1; wr_off = start_q; wr_dat = sval_q + h + HW'(Hdr);
          cnt_d = cnt_q + HW'(Hdr);
        end
        fin = 1'b1; out_d.status = StOk;
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      out_valid_d      = 1'b1;
      out_d.free_bytes = cnt_d[11:0];
      state_d          = S_IDLE;
    end
  end

  // header store: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_off[IW:1]] <= wr_dat;
    if (rd_en) rdat_q <= mem[rd_off[IW:1]];
    job_q      <= job_d;
    out_q      <= out_d;
    off_q      <= off_d;
    prev_q     <= prev_d;
    best_off_q <= best_off_d;
    best_d_q   <= best_d_d;
    hsz_q      <= hsz_d;
    sval_q     <= sval_d;
    start_q    <= start_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= InitHdr;
      have_prev_q <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      e0_wr_q     <= 1'b0;
      rz_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      have_prev_q <= have_prev_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (wr_en && wr_off[IW:1] == '0) e0_wr_q <= 1'b1;
      if (rd_en) rz_q <= (rd_off[IW:1] == '0) && !e0_wr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: hw/rtl/best_fit_heap_allocator.sv
// Sequencing: an early reject finishes from idle; an allocate reads and evaluates
//   each chunk it visits, then commits, with one more write state when it splits;
//   a free checks, reads and evaluates each chunk ahead of it, then frees the target
//   and merges it with free neighbours, all on the header store's single read port.
// Throughput: one word at a time in the back end; the front queue holds two more.
// Reset: asynchronous, active low; heap comes up as one free chunk, no clearing pass.
`timescale 1ns / 1ps
module best_fit_heap_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bfha_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bfha_pkg::out_word_t out_word_o
);
  import bfha_pkg::*;

  // front: early checks (zero size, bad free offset), size rounding, queue
  job_t job;
  logic job_valid, job_pop;

  bfha_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .job_valid_o (job_valid),
    .job_pop_i   (job_pop),
    .job_o       (job)
  );

  // back: walks the chunk headers, commits splits and merges, holds result
  bfha_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: hw/rtl/bfha_checker.sv
`timescale 1ns / 1ps
module bfha_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input bfha_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bfha_pkg::out_word_t out_word_o
);
  import bfha_pkg::*;

  a_pay_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != StOk |-> out_word_o.payload_offset == '0)
    else $error("payload offset set on reject");

  a_free_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.free_bytes <= 12'(Span - Hdr))
    else $error("free count beyond heap");

  a_pay_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == StOk && out_word_o.payload_offset != '0
      |-> out_word_o.payload_offset >= 12'(Hdr))
    else $error("payload overlaps header");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (.*);
